### rtl/core/sqw_pkg.sv
// ----------------------------------------------------------------------------
// sqw_pkg
// Shared types, codes and constant tables of the square wave channel.
// ----------------------------------------------------------------------------
package sqw_pkg;

   typedef enum logic [1:0] {
      OP_BASE_TICK  = 2'd0,
      OP_FRAME_TICK = 2'd1,
      OP_TRIGGER    = 2'd2
   } op_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DUTY_SELECT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_VOLUME  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENVELOPE_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENVELOPE_UP     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH_ENABLE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQUENCY       = 3'd5;

   localparam logic [7:0]  MID_LEVEL   = 8'h80;
   localparam logic [3:0]  MAX_VOLUME  = 4'hF;
   localparam logic [2:0]  FRAME_GROUP = 3'd4;
   localparam logic [11:0] PERIOD_BASE = 12'd2048;

   localparam logic [7:0] LEVEL_TABLE [16] = '{
      8'd0,  8'd8,  8'd17, 8'd25, 8'd34,  8'd42,  8'd51,  8'd59,
      8'd68, 8'd76, 8'd85, 8'd93, 8'd102, 8'd110, 8'd119, 8'd127
   };

   // Bit n of each pattern is the level of step n.
   localparam logic [7:0] DUTY_TABLE [4] = '{
      8'b0001_0000,
      8'b0011_0000,
      8'b0011_1100,
      8'b1100_1111
   };

   typedef struct packed {
      logic [1:0]  duty_select;
      logic [3:0]  initial_volume;
      logic [2:0]  envelope_period;
      logic        envelope_up;
      logic        length_enable;
      logic [10:0] frequency;
   } cfg_type;

   typedef struct packed {
      logic [7:0] sample;
      logic       key_on;
   } result_type;

endpackage

### rtl/core/sqw_core.sv
// ----------------------------------------------------------------------------
// sqw_core
// Channel state: period counter, duty sequencer, envelope and length counter.
// ----------------------------------------------------------------------------
module sqw_core import sqw_pkg::*; #(
   parameter int LENGTH_BITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] opcode,
   input  logic [5:0] length_load,
   input  cfg_type    cfg,
   output result_type result
);

   logic [12:0]            period_count_ff, period_count_in;
   logic [2:0]             wave_step_ff, wave_step_in;
   logic [3:0]             volume_level_ff, volume_level_in;
   logic [7:0]             sample_buffer_ff, sample_buffer_in;
   logic [2:0]             frame_divider_ff, frame_divider_in;
   logic [2:0]             envelope_count_ff, envelope_count_in;
   logic [LENGTH_BITS-1:0] length_count_ff, length_count_in;
   logic                   start_pending_ff, start_pending_in;
   logic                   sounding_ff, sounding_in;

   logic [12:0]            period_limit;
   logic                   silent;
   logic [2:0]             step_now;
   logic [3:0]             volume_now;
   logic [7:0]             level;
   logic [2:0]             divider_next;
   logic [2:0]             env_count_next;
   logic [LENGTH_BITS+5:0] load_wide;
   op_type                 op;

   assign op           = op_type'(opcode);
   assign period_limit = {PERIOD_BASE - {1'b0, cfg.frequency}, 1'b0};
   assign silent       = (cfg.initial_volume == 4'd0 && !cfg.envelope_up &&
                          cfg.envelope_period == 3'd0) ||
                         (cfg.length_enable && length_count_ff == '0);
   assign step_now     = start_pending_ff ? 3'd0 : wave_step_ff;
   assign volume_now   = start_pending_ff ? cfg.initial_volume : volume_level_ff;
   assign level        = LEVEL_TABLE[volume_now];
   assign divider_next = frame_divider_ff + 3'd1;
   assign env_count_next = envelope_count_ff + 3'd1;
   assign load_wide    = {{LENGTH_BITS{1'b0}}, length_load};

   always_comb begin
      period_count_in   = period_count_ff;
      wave_step_in      = wave_step_ff;
      volume_level_in   = volume_level_ff;
      sample_buffer_in  = sample_buffer_ff;
      frame_divider_in  = frame_divider_ff;
      envelope_count_in = envelope_count_ff;
      length_count_in   = length_count_ff;
      start_pending_in  = start_pending_ff;
      sounding_in       = sounding_ff;
      if (accept) begin
         case (op)
            OP_BASE_TICK: begin
               if (period_count_ff >= period_limit) begin
                  period_count_in = '0;
                  if (silent) begin
                     sample_buffer_in = MID_LEVEL;
                     sounding_in      = 1'b0;
                  end else begin
                     if (start_pending_ff) begin
                        start_pending_in = 1'b0;
                        sounding_in      = 1'b1;
                     end
                     volume_level_in  = volume_now;
                     sample_buffer_in = DUTY_TABLE[cfg.duty_select][step_now] ?
                                        MID_LEVEL + level : MID_LEVEL - level;
                     wave_step_in     = step_now + 3'd1;
                  end
               end else begin
                  period_count_in = period_count_ff + 13'd1;
               end
            end
            OP_FRAME_TICK: begin
               frame_divider_in = divider_next;
               if (divider_next >= FRAME_GROUP) begin
                  frame_divider_in = '0;
                  if (cfg.envelope_period != 3'd0) begin
                     envelope_count_in = env_count_next;
                     if (cfg.envelope_period <= env_count_next) begin
                        envelope_count_in = '0;
                        if (cfg.envelope_up) begin
                           if (volume_level_ff < MAX_VOLUME) begin
                              volume_level_in = volume_level_ff + 4'd1;
                           end
                        end else if (volume_level_ff != 4'd0) begin
                           volume_level_in = volume_level_ff - 4'd1;
                        end
                     end
                  end
               end
               if (cfg.length_enable && length_count_ff != '0) begin
                  length_count_in = length_count_ff + 1'b1;
               end
            end
            OP_TRIGGER: begin
               start_pending_in = 1'b1;
               length_count_in  = load_wide[LENGTH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff   <= '0;
         wave_step_ff      <= '0;
         volume_level_ff   <= '0;
         sample_buffer_ff  <= MID_LEVEL;
         frame_divider_ff  <= '0;
         envelope_count_ff <= '0;
         length_count_ff   <= '0;
         start_pending_ff  <= 1'b0;
         sounding_ff       <= 1'b0;
      end else begin
         period_count_ff   <= period_count_in;
         wave_step_ff      <= wave_step_in;
         volume_level_ff   <= volume_level_in;
         sample_buffer_ff  <= sample_buffer_in;
         frame_divider_ff  <= frame_divider_in;
         envelope_count_ff <= envelope_count_in;
         length_count_ff   <= length_count_in;
         start_pending_ff  <= start_pending_in;
         sounding_ff       <= sounding_in;
      end
   end

   // The result word carries the state as it stands once this word is applied.
   assign result.sample = sample_buffer_in;
   assign result.key_on = sounding_in;

`ifndef SYNTHESIS
   a_sound_starts_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(sounding_ff) |-> $past(accept && opcode == OP_BASE_TICK))
      else $error("sounding began without a base tick");

   a_start_taken_sounds: assert property (@(posedge clock) disable iff (reset)
      $fell(start_pending_ff) |-> sounding_ff)
      else $error("pending start cleared without the channel sounding");
`endif

endmodule

### rtl/core/square_wave_channel.sv
// ----------------------------------------------------------------------------
// square_wave_channel
// Pulse sound channel with duty sequencer, volume envelope and length counter.
// ----------------------------------------------------------------------------
// Every word taken on req_ (base tick, frame tick or key-on trigger) yields
// exactly one word on rsp_ with the channel's sample byte and key-on flag as
// they stand after that event. One word is accepted per clock while req_ready
// is high; the state is updated in the accepting cycle and the result is
// registered in the output buffer. A two-entry output buffer (result register
// plus skid register) lets req_ take one more word while rsp_ is stalled,
// after which req_ready stays low until rsp_ takes the held word. Registers
// on the csr_ port should only change while the channel is idle.
module square_wave_channel import sqw_pkg::*; #(
   parameter int LENGTH_BITS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [5:0]                req_length_load,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_sample,
   output logic                      rsp_key_on,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       push;
   logic       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DUTY_SELECT:     cfg_in.duty_select     = csr_wdata[1:0];
            CSR_INITIAL_VOLUME:  cfg_in.initial_volume  = csr_wdata[3:0];
            CSR_ENVELOPE_PERIOD: cfg_in.envelope_period = csr_wdata[2:0];
            CSR_ENVELOPE_UP:     cfg_in.envelope_up     = csr_wdata[0];
            CSR_LENGTH_ENABLE:   cfg_in.length_enable   = csr_wdata[0];
            CSR_FREQUENCY:       cfg_in.frequency       = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   sqw_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (push),
      .opcode      (req_opcode),
      .length_load (req_length_load),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // The skid register only fills when a word arrives while the result
   // register is held; it is drained first so order is kept.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pop || !out_valid_ff) begin
         out_in       = result;
         out_valid_in = push;
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{duty_select: 2'd2, default: '0};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_ff.sample;
   assign rsp_key_on = out_ff.key_on;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word ahead of the result register");

   a_stalled_push_skids: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("word accepted under a stall was not kept in the skid register");
`endif

endmodule
